[rtl/core/lemfs_pkg.sv]
// Shared types, constants and fixed-point helpers of the mean-flow source block.
// Used by every module under rtl/core except lemfs_ram; depends on nothing else.
`default_nettype none
package lemfs_pkg;

  localparam int MAX_NODES = 4;
  localparam int FRAC_BITS = 16;
  localparam int W         = 32;
  localparam int VOL_W     = 31;
  localparam int GAMMA_W   = 19;
  localparam int TSTEP_W   = 31;
  localparam int NGRAD     = 6;
  localparam int GRAD_W    = 64;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int GI_W      = $clog2(NGRAD + 1);
  localparam int ADDR_W    = $clog2(2 * MAX_NODES);
  localparam int SUM_W     = W + $clog2(MAX_NODES) + 1;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DVS_W     = 34;
  localparam int DIV_STEPS = 64;
  localparam int DSTEP_W   = $clog2(DIV_STEPS);
  localparam int S_DATA_W  = 352;
  localparam int M_DATA_W  = 128;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 31;
  localparam int NODE_W    = 7 * W;

  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TSTEP = 1'b1;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 19'd91750;
  localparam logic [TSTEP_W-1:0] TSTEP_RESET = 31'd65536;
  localparam logic [MUL_W-1:0]   Q_ONE       = MUL_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [W-1:0] rho0;
    logic signed [W-1:0] u0;
    logic signed [W-1:0] v0;
    logic signed [W-1:0] rho;
    logic signed [W-1:0] mx;
    logic signed [W-1:0] my;
    logic signed [W-1:0] p;
  } node_t;

  typedef struct packed {
    logic [NGRAD-1:0][GRAD_W-1:0] sums;
    logic [CNT_W-1:0]             count;
    logic [VOL_W-1:0]             vol;
    logic                         err;
    logic                         bank;
  } job_t;

  function automatic logic signed [W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [W-1:0] r;
    if (v[PROD_W-1:W-1] == {(PROD_W-W+1){v[PROD_W-1]}})
      r = v[W-1:0];
    else if (v[PROD_W-1])
      r = {1'b1, {(W-1){1'b0}}};
    else
      r = {1'b0, {(W-1){1'b1}}};
    return r;
  endfunction

  function automatic logic [GRAD_W-1:0] satadd64(input logic [GRAD_W-1:0] a,
                                                 input logic [GRAD_W-1:0] b);
    logic [GRAD_W:0]   s;
    logic [GRAD_W-1:0] r;
    s = {a[GRAD_W-1], a} + {b[GRAD_W-1], b};
    if (s[GRAD_W] != s[GRAD_W-1])
      r = s[GRAD_W] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
    else
      r = s[GRAD_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/lemfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none
module lemfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/lemfs_front.sv]
// Front end: accepts node words, stores nodes, accumulates normal-times-value sums.
// Pushes one cell job per last node. Depends on lemfs_pkg.
`default_nettype none
module lemfs_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [lemfs_pkg::S_DATA_W-1:0]     s_tdata,
  input  wire logic                               s_tlast,
  input  wire logic                               q_full,
  output logic                                    push,
  output lemfs_pkg::job_t                         job,
  output logic                                    ram_we,
  output logic [lemfs_pkg::ADDR_W-1:0]            ram_waddr,
  output lemfs_pkg::node_t                        ram_wdata
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_END} state_t;

  state_t                                                 state;
  logic signed [lemfs_pkg::W-1:0]                         nx, ny, u0, v0, pr;
  logic signed [lemfs_pkg::W-1:0]                         opa, opb;
  logic signed [lemfs_pkg::GRAD_W-1:0]                    mprod;
  logic [lemfs_pkg::NGRAD-1:0][lemfs_pkg::GRAD_W-1:0]     sums;
  logic [lemfs_pkg::CNT_W-1:0]                            count;
  logic [lemfs_pkg::VOL_W-1:0]                            vol_r;
  logic [2:0]                                             k, kp;
  logic                                                   last_r, overflow, zrho, bank;
  logic                                                   accept, room;
  lemfs_pkg::node_t                                       in_node;

  assign in_node.rho0 = s_tdata[64+:32];
  assign in_node.u0   = s_tdata[96+:32];
  assign in_node.v0   = s_tdata[128+:32];
  assign in_node.rho  = s_tdata[192+:32];
  assign in_node.mx   = s_tdata[224+:32];
  assign in_node.my   = s_tdata[256+:32];
  assign in_node.p    = s_tdata[288+:32];

  assign s_tready  = (state == F_IDLE) && !q_full;
  assign accept    = s_tvalid && s_tready;
  assign room      = count < lemfs_pkg::CNT_W'(lemfs_pkg::MAX_NODES);
  assign ram_we    = accept && room;
  assign ram_waddr = lemfs_pkg::ADDR_W'(bank ? lemfs_pkg::MAX_NODES : 0)
                   + lemfs_pkg::ADDR_W'(count);
  assign ram_wdata = in_node;
  assign kp        = k - 3'd1;

  always_comb begin
    case (k)
      3'd0:    begin opa = nx; opb = u0; end
      3'd1:    begin opa = ny; opb = u0; end
      3'd2:    begin opa = nx; opb = v0; end
      3'd3:    begin opa = ny; opb = v0; end
      3'd4:    begin opa = nx; opb = pr; end
      3'd5:    begin opa = ny; opb = pr; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign push       = (state == F_END) && last_r;
  assign job.sums   = sums;
  assign job.count  = count;
  assign job.vol    = vol_r;
  assign job.err    = overflow || (vol_r == '0) || (count == '0) || zrho;
  assign job.bank   = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      zrho     <= 1'b0;
      bank     <= 1'b0;
      sums     <= '0;
      k        <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            last_r <= s_tlast;
            vol_r  <= s_tdata[320+:lemfs_pkg::VOL_W];
            if (room) begin
              nx    <= s_tdata[0+:32];
              ny    <= s_tdata[32+:32];
              u0    <= in_node.u0;
              v0    <= in_node.v0;
              pr    <= s_tdata[160+:32];
              count <= count + 1'b1;
              zrho  <= zrho || (in_node.rho0 == '0);
              k     <= '0;
              state <= F_MUL;
            end else begin
              overflow <= 1'b1;
              state    <= F_END;
            end
          end
        end
        F_MUL: begin
          mprod <= opa * opb;
          if (k != 3'd0) begin
            sums[kp] <= lemfs_pkg::satadd64(sums[kp], mprod);
          end
          if (k == 3'(lemfs_pkg::NGRAD)) begin
            state <= F_END;
          end else begin
            k <= k + 3'd1;
          end
        end
        F_END: begin
          if (last_r) begin
            sums     <= '0;
            count    <= '0;
            overflow <= 1'b0;
            zrho     <= 1'b0;
            bank     <= ~bank;
          end
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/lemfs_queue.sv]
// Two-entry job queue between front and back ends.
// Depends on lemfs_pkg for the job type.
`default_nettype none
module lemfs_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire lemfs_pkg::job_t  job_in,
  input  wire logic             pop,
  output lemfs_pkg::job_t       head,
  output logic                  empty,
  output logic                  full
);

  lemfs_pkg::job_t mem [2];
  logic [1:0]      cnt;
  logic            wp, rp;

  assign empty = (cnt == 2'd0);
  assign full  = (cnt == 2'd2);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        mem[wp] <= job_in;
        wp      <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

[rtl/core/lemfs_div.sv]
// Radix-2 restoring divider: signed 64-bit by signed 34-bit, truncating,
// quotient saturated to 32 bits. Depends on lemfs_pkg.
`default_nettype none
module lemfs_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic signed [lemfs_pkg::GRAD_W-1:0]  dvd,
  input  wire logic signed [lemfs_pkg::DVS_W-1:0]   dvs,
  output logic                                      done,
  output logic signed [lemfs_pkg::W-1:0]            q
);

  logic                                busy, neg, ge;
  logic [lemfs_pkg::DSTEP_W-1:0]       cnt;
  logic [lemfs_pkg::GRAD_W-1:0]        num, mag_dvd;
  logic [lemfs_pkg::DVS_W-2:0]         den, rem, rem_nx;
  logic [lemfs_pkg::DVS_W-1:0]         rem_sh, rem_sub, mag_dvs;

  assign mag_dvd = dvd[lemfs_pkg::GRAD_W-1] ? (~dvd + 1'b1) : dvd;
  assign mag_dvs = dvs[lemfs_pkg::DVS_W-1] ? (~dvs + 1'b1) : dvs;
  assign rem_sh  = {rem, num[lemfs_pkg::GRAD_W-1]};
  assign ge      = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};
  assign rem_nx  = ge ? rem_sub[lemfs_pkg::DVS_W-2:0] : rem_sh[lemfs_pkg::DVS_W-2:0];

  always_comb begin
    if (neg) begin
      if (num > lemfs_pkg::GRAD_W'(64'h8000_0000))
        q = {1'b1, {(lemfs_pkg::W-1){1'b0}}};
      else
        q = -$signed(num[lemfs_pkg::W-1:0]);
    end else begin
      if (num > lemfs_pkg::GRAD_W'(64'h7fff_ffff))
        q = {1'b0, {(lemfs_pkg::W-1){1'b1}}};
      else
        q = num[lemfs_pkg::W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= mag_dvd;
        den  <= mag_dvs[lemfs_pkg::DVS_W-2:0];
        rem  <= '0;
        neg  <= dvd[lemfs_pkg::GRAD_W-1] ^ dvs[lemfs_pkg::DVS_W-1];
      end else if (busy) begin
        rem <= rem_nx;
        num <= {num[lemfs_pkg::GRAD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == lemfs_pkg::DSTEP_W'(lemfs_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/lemfs_back.sv]
// Back end: turns one cell job into gradients, per-node source terms and the result.
// Depends on lemfs_pkg and lemfs_div; reads nodes from the node RAM.
`default_nettype none
module lemfs_back (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lemfs_pkg::job_t                     job,
  input  wire logic                                q_empty,
  output logic                                     pop,
  output logic [lemfs_pkg::ADDR_W-1:0]             ram_raddr,
  input  wire lemfs_pkg::node_t                    ram_rdata,
  input  wire logic [lemfs_pkg::GAMMA_W-1:0]       gamma,
  input  wire logic [lemfs_pkg::TSTEP_W-1:0]       tstep,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [lemfs_pkg::M_DATA_W-1:0]           m_tdata,
  output logic                                     m_tuser
);

  typedef enum logic [4:0] {
    B_IDLE, B_GDIV, B_GDIVW, B_DIV, B_VH, B_VH2, B_RD, B_LAT,
    N_RU, N_RV, N_D1, N_D1W, N_D2W, N_AG0, N_BG1, N_AG2, N_BG3, N_DG4, N_DG5,
    N_GP, N_GPD, N_GT, N_S3,
    F_D1, F_W1, F_M1, F_W2, F_M2, F_W3, F_M3, B_OUT
  } state_t;

  state_t                                           state;
  lemfs_pkg::node_t                                 nd;
  logic [lemfs_pkg::NGRAD-1:0][lemfs_pkg::W-1:0]    g;
  logic [lemfs_pkg::GI_W-1:0]                       gi;
  logic [lemfs_pkg::CNT_W-1:0]                      i;
  logic signed [lemfs_pkg::W-1:0]                   divv, vh, a, b, d1, d2, t, acc, qm;
  logic signed [lemfs_pkg::W-1:0]                   res0, res1, res2, o_mx, o_my, o_en;
  logic signed [lemfs_pkg::SUM_W-1:0]               s1, s2, s3;
  logic signed [lemfs_pkg::MUL_W-1:0]               ma, mb, gm1;
  logic signed [lemfs_pkg::PROD_W-1:0]              mprod;
  logic                                             o_err, div_start, div_done, slot;
  logic signed [lemfs_pkg::GRAD_W-1:0]              dvd;
  logic signed [lemfs_pkg::DVS_W-1:0]               dvs;
  logic signed [lemfs_pkg::W-1:0]                   div_q;

  lemfs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dvd   (dvd),
    .dvs   (dvs),
    .done  (div_done),
    .q     (div_q)
  );

  assign gm1       = $signed(lemfs_pkg::MUL_W'(gamma) - lemfs_pkg::Q_ONE);
  assign qm        = lemfs_pkg::sat32(mprod >>> lemfs_pkg::FRAC_BITS);
  assign ram_raddr = lemfs_pkg::ADDR_W'(job.bank ? lemfs_pkg::MAX_NODES : 0)
                   + lemfs_pkg::ADDR_W'(i);
  assign slot      = !m_tvalid || m_tready;
  assign pop       = (state == B_OUT) && slot;
  assign m_tdata   = {o_en, o_my, o_mx, lemfs_pkg::W'(0)};
  assign m_tuser   = o_err;

  assign div_start = (state == B_GDIV) || (state == N_D1) || (state == F_D1)
                  || (state == F_M1) || (state == F_M2)
                  || ((state == N_D1W) && div_done);

  always_comb begin
    dvd = '0;
    dvs = '0;
    case (state)
      B_GDIV: begin
        dvd = $signed(job.sums[gi]);
        dvs = $signed(lemfs_pkg::DVS_W'({job.vol, 1'b0}));
      end
      N_D1: begin
        dvd = lemfs_pkg::GRAD_W'(nd.mx) <<< lemfs_pkg::FRAC_BITS;
        dvs = lemfs_pkg::DVS_W'(nd.rho0);
      end
      N_D1W: begin
        dvd = lemfs_pkg::GRAD_W'(nd.my) <<< lemfs_pkg::FRAC_BITS;
        dvs = lemfs_pkg::DVS_W'(nd.rho0);
      end
      F_D1: begin
        dvd = lemfs_pkg::GRAD_W'(s1);
        dvs = $signed(lemfs_pkg::DVS_W'(job.count));
      end
      F_M1: begin
        dvd = lemfs_pkg::GRAD_W'(s2);
        dvs = $signed(lemfs_pkg::DVS_W'(job.count));
      end
      F_M2: begin
        dvd = lemfs_pkg::GRAD_W'(s3);
        dvs = $signed(lemfs_pkg::DVS_W'(job.count));
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  always_comb begin
    case (state)
      B_VH:    begin ma = $signed(lemfs_pkg::MUL_W'(job.vol));
                     mb = $signed(lemfs_pkg::MUL_W'(tstep >> 1)); end
      N_RU:    begin ma = lemfs_pkg::MUL_W'(nd.rho); mb = lemfs_pkg::MUL_W'(nd.u0); end
      N_RV:    begin ma = lemfs_pkg::MUL_W'(nd.rho); mb = lemfs_pkg::MUL_W'(nd.v0); end
      N_AG0:   begin ma = lemfs_pkg::MUL_W'(a); mb = lemfs_pkg::MUL_W'($signed(g[0])); end
      N_BG1:   begin ma = lemfs_pkg::MUL_W'(b); mb = lemfs_pkg::MUL_W'($signed(g[1])); end
      N_AG2:   begin ma = lemfs_pkg::MUL_W'(a); mb = lemfs_pkg::MUL_W'($signed(g[2])); end
      N_BG3:   begin ma = lemfs_pkg::MUL_W'(b); mb = lemfs_pkg::MUL_W'($signed(g[3])); end
      N_DG4:   begin ma = lemfs_pkg::MUL_W'(d1); mb = lemfs_pkg::MUL_W'($signed(g[4])); end
      N_DG5:   begin ma = lemfs_pkg::MUL_W'(d2); mb = lemfs_pkg::MUL_W'($signed(g[5])); end
      N_GP:    begin ma = gm1; mb = lemfs_pkg::MUL_W'(nd.p); end
      N_GPD:   begin ma = lemfs_pkg::MUL_W'(qm); mb = lemfs_pkg::MUL_W'(divv); end
      N_GT:    begin ma = gm1; mb = lemfs_pkg::MUL_W'(t); end
      F_W1, F_W2, F_W3:
               begin ma = lemfs_pkg::MUL_W'(div_q); mb = lemfs_pkg::MUL_W'(vh); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      mprod <= ma * mb;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            res0 <= '0;
            res1 <= '0;
            res2 <= '0;
            gi   <= '0;
            s1   <= '0;
            s2   <= '0;
            s3   <= '0;
            state <= job.err ? B_OUT : B_GDIV;
          end
        end
        B_GDIV:  state <= B_GDIVW;
        B_GDIVW: begin
          if (div_done) begin
            g[gi] <= div_q;
            gi    <= gi + 1'b1;
            state <= (gi == lemfs_pkg::GI_W'(lemfs_pkg::NGRAD - 1)) ? B_DIV : B_GDIV;
          end
        end
        B_DIV: begin
          divv  <= lemfs_pkg::sat32(lemfs_pkg::PROD_W'($signed(g[0]))
                                  + lemfs_pkg::PROD_W'($signed(g[3])));
          state <= B_VH;
        end
        B_VH:  state <= B_VH2;
        B_VH2: begin
          vh    <= qm;
          i     <= '0;
          state <= B_RD;
        end
        B_RD:  state <= B_LAT;
        B_LAT: begin
          nd    <= ram_rdata;
          state <= N_RU;
        end
        N_RU:  state <= N_RV;
        N_RV: begin
          a     <= lemfs_pkg::sat32(lemfs_pkg::PROD_W'(qm) + lemfs_pkg::PROD_W'(nd.mx));
          state <= N_D1;
        end
        N_D1: begin
          b     <= lemfs_pkg::sat32(lemfs_pkg::PROD_W'(qm) + lemfs_pkg::PROD_W'(nd.my));
          state <= N_D1W;
        end
        N_D1W: begin
          if (div_done) begin
            d1    <= div_q;
            state <= N_D2W;
          end
        end
        N_D2W: begin
          if (div_done) begin
            d2    <= div_q;
            state <= N_AG0;
          end
        end
        N_AG0: state <= N_BG1;
        N_BG1: begin
          acc   <= qm;
          state <= N_AG2;
        end
        N_AG2: begin
          s1    <= s1 + lemfs_pkg::SUM_W'(lemfs_pkg::sat32(lemfs_pkg::PROD_W'(acc)
                                                        + lemfs_pkg::PROD_W'(qm)));
          state <= N_BG3;
        end
        N_BG3: begin
          acc   <= qm;
          state <= N_DG4;
        end
        N_DG4: begin
          s2    <= s2 + lemfs_pkg::SUM_W'(lemfs_pkg::sat32(lemfs_pkg::PROD_W'(acc)
                                                        + lemfs_pkg::PROD_W'(qm)));
          state <= N_DG5;
        end
        N_DG5: begin
          acc   <= qm;
          state <= N_GP;
        end
        N_GP: begin
          t     <= lemfs_pkg::sat32(lemfs_pkg::PROD_W'(acc) + lemfs_pkg::PROD_W'(qm));
          state <= N_GPD;
        end
        N_GPD: state <= N_GT;
        N_GT: begin
          acc   <= qm;
          state <= N_S3;
        end
        N_S3: begin
          s3    <= s3 + lemfs_pkg::SUM_W'(lemfs_pkg::sat32(lemfs_pkg::PROD_W'(acc)
                                                        - lemfs_pkg::PROD_W'(qm)));
          i     <= i + 1'b1;
          state <= (lemfs_pkg::CNT_W'(i + 1'b1) == job.count) ? F_D1 : B_RD;
        end
        F_D1: state <= F_W1;
        F_W1: if (div_done) state <= F_M1;
        F_M1: begin
          res0  <= qm;
          state <= F_W2;
        end
        F_W2: if (div_done) state <= F_M2;
        F_M2: begin
          res1  <= qm;
          state <= F_W3;
        end
        F_W3: if (div_done) state <= F_M3;
        F_M3: begin
          res2  <= qm;
          state <= B_OUT;
        end
        B_OUT: begin
          if (slot) begin
            m_tvalid <= 1'b1;
            o_mx     <= res0;
            o_my     <= res1;
            o_en     <= res2;
            o_err    <= job.err;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/lin_euler_mean_flow_source.sv]
// Top level of the mean-flow source block: config registers, front end, job queue,
// node RAM and back end. Depends on lemfs_pkg and all lemfs_* modules.
//
// Usage:
//   s_* channel carries one node word per mesh node; s_tlast marks a cell's last node.
//   m_* channel carries one result word per cell; m_tuser is the error flag.
//   cfg_we/cfg_index/cfg_data write gamma (index 0) or the time step (index 1);
//   write only while no cell is in flight.
// Structure:
//   The front end forms a node's 6 products through one multiplier and takes the next
//   node only when done with the last. The back end runs a restoring divider for
//   6 gradient divisions per cell, two per node and three for the averages.
//   A two-entry job queue and a two-bank node RAM let the front end fill the next
//   cell while the back end works; s_tready drops while two cells wait.
// Reset (synchronous, rst high) empties the queue, clears the sums and counts and
// loads gamma 1.4 and time step 1.0. A stalled m_tready holds the result word; the
// back end waits for the slot and the front end keeps taking nodes until the queue fills.
`default_nettype none
module lin_euler_mean_flow_source (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // normal_x, normal_y, mean_density, mean_vel_x, mean_vel_y, mean_pressure,
  // pert_density, pert_mom_x, pert_mom_y, pert_pressure, cell_volume, zero pad
  input  wire logic [lemfs_pkg::S_DATA_W-1:0]       s_tdata,
  input  wire logic                                 s_tlast,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // source_mass, source_mom_x, source_mom_y, source_energy
  output logic [lemfs_pkg::M_DATA_W-1:0]            m_tdata,
  // math_error
  output logic                                      m_tuser,
  input  wire logic                                 cfg_we,
  input  wire logic [lemfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lemfs_pkg::CFG_W-1:0]          cfg_data
);

  logic [lemfs_pkg::GAMMA_W-1:0]  gamma;
  logic [lemfs_pkg::TSTEP_W-1:0]  tstep;
  logic                           push, pop, q_empty, q_full, ram_we;
  lemfs_pkg::job_t                job_in, q_head;
  logic [lemfs_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  lemfs_pkg::node_t               ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= lemfs_pkg::GAMMA_RESET;
      tstep <= lemfs_pkg::TSTEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lemfs_pkg::CFG_GAMMA: gamma <= cfg_data[lemfs_pkg::GAMMA_W-1:0];
        lemfs_pkg::CFG_TSTEP: tstep <= cfg_data[lemfs_pkg::TSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  lemfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .job       (job_in),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  lemfs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job_in (job_in),
    .pop    (pop),
    .head   (q_head),
    .empty  (q_empty),
    .full   (q_full)
  );

  lemfs_ram #(
    .WIDTH (lemfs_pkg::NODE_W),
    .DEPTH (2 * lemfs_pkg::MAX_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lemfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_head),
    .q_empty   (q_empty),
    .pop       (pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .gamma     (gamma),
    .tstep     (tstep),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[lemfs_pkg::M_DATA_W-1:lemfs_pkg::W] == '0)
    else $error("error result carries nonzero sources");
  a_mass_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[lemfs_pkg::W-1:0] == '0)
    else $error("mass source not zero");
  a_bank_free: assert property (@(posedge clk) disable iff (rst)
    ram_we && !q_empty |->
      ((ram_waddr >= lemfs_pkg::ADDR_W'(lemfs_pkg::MAX_NODES)) != q_head.bank))
    else $error("node write into bank in use by back end");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !s_tready)
    else $error("node accepted with job queue full");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full || pop)
    else $error("job pushed into full queue");
`endif

endmodule
`default_nettype wire
